/* src/sfce_pkg.sv */
// Package for the SPI serial flash command engine: command codes, identity
// bytes, default geometry, beat layout widths and the controller enums.
// No dependencies; imported by the top level.
package sfce_pkg;

    // Default store geometry (address, page and sector widths in bits).
    localparam int ADDR_BITS_DEF   = 18;
    localparam int PAGE_BITS_DEF   = 8;
    localparam int SECTOR_BITS_DEF = 16;

    // Fixed field widths of the beats.
    localparam int BYTE_W      = 8;
    localparam int LOAD_ADDR_W = 18;
    localparam int POS_W       = 3;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;

    // Byte position within a selection saturates here.
    localparam logic [POS_W-1:0] POS_MAX = 3'd5;

    // Command codes.
    localparam logic [BYTE_W-1:0] CMD_WREN = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_WRDI = 8'h04;
    localparam logic [BYTE_W-1:0] CMD_RDID = 8'h95;
    localparam logic [BYTE_W-1:0] CMD_RDSR = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_READ = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_FAST = 8'h0B;
    localparam logic [BYTE_W-1:0] CMD_PW   = 8'h0A;
    localparam logic [BYTE_W-1:0] CMD_PP   = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_PE   = 8'hDB;
    localparam logic [BYTE_W-1:0] CMD_SE   = 8'hD8;
    localparam logic [BYTE_W-1:0] CMD_DP   = 8'hB9;
    localparam logic [BYTE_W-1:0] CMD_RDP  = 8'hAB;
    localparam logic [BYTE_W-1:0] CMD_NONE = 8'h00;

    // Identification bytes returned by RDID.
    localparam logic [BYTE_W-1:0] ID_MAKER = 8'h20;
    localparam logic [BYTE_W-1:0] ID_TYPE  = 8'h40;
    localparam logic [BYTE_W-1:0] ID_SIZE  = 8'h12;

    // Value of an erased byte.
    localparam logic [BYTE_W-1:0] BYTE_ERASED = 8'hFF;

    // Kind of an input beat.
    typedef enum logic [1:0] {
        KIND_XCHG    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_LOAD    = 2'd2
    } kind_t;

    // Store operation chosen when a beat is decoded.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_READ,
        ACT_AND,
        ACT_WRITE,
        ACT_ERASE_PAGE,
        ACT_ERASE_SECTOR,
        ACT_ERASE_WRITE
    } action_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_ERASE,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

/* src/spi_serial_flash_command_engine.sv */
// SPI serial flash command engine, flash side: command decode and store
// controller around one byte-wide RAM. Depends on sfce_pkg and sfce_ram.
//
// Usage. Each slave-side beat is one exchanged SPI byte, a chip-select
// release or a preload write into the byte store; each produces exactly one
// master-side beat with the returned byte, the write-enable latch and the
// deep power-down flag as they stand after that beat. The single
// configuration register (write protection of the first sector) is written
// whenever cfg_wr_en is high, and should only change while the engine is idle.
// Timing. A beat is taken only while the controller is idle. A plain beat
// passes through decode and done, a read or page program also through read;
// the next beat is taken only after the last one's result is registered.
// Page erase walks the page and sector erase walks the sector, one byte per
// cycle; the first data byte of a page write also walks its page and is then
// written in the write state. The single RAM port, one access per cycle,
// sets this pace.
// Reset clears the command, position, address, latch and power-down flags
// and sets write protection; the store keeps its contents and reads as
// undefined until written. If the receiver stalls, the result waits in the
// output register; the engine still takes and works on one more beat and
// then holds it until the output register is free.
module spi_serial_flash_command_engine #(
    parameter int ADDR_BITS   = sfce_pkg::ADDR_BITS_DEF,
    parameter int PAGE_BITS   = sfce_pkg::PAGE_BITS_DEF,
    parameter int SECTOR_BITS = sfce_pkg::SECTOR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Slave side: tdata = {load_address[17:0], mosi_byte[7:0]} from bit 0,
    // zero padded to 32 bits.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sfce_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser = {keep_selected, kind[1:0]} from bit 0.
    input  logic [sfce_pkg::S_TUSER_W-1:0] s_tuser,
    // Master side: tdata = miso_byte[7:0].
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sfce_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser = {powered_down, write_enabled} from bit 0.
    output logic [sfce_pkg::M_TUSER_W-1:0] m_tuser,
    // Configuration: write_protect.
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data
);

    import sfce_pkg::*;

    localparam int SEC_SPAN = (SECTOR_BITS < ADDR_BITS) ? SECTOR_BITS : ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] PAGE_MASK = ADDR_BITS'((64'd1 << PAGE_BITS) - 64'd1);
    localparam logic [ADDR_BITS-1:0] SEC_MASK  = ADDR_BITS'((64'd1 << SEC_SPAN) - 64'd1);

    // Registers.
    state_t                 state_reg, state_next;
    logic                   protect_reg;
    logic [BYTE_W-1:0]      cmd_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [ADDR_BITS-1:0]   addr_reg;
    logic                   latch_reg;
    logic                   sleep_reg;
    logic                   spend_reg;
    logic                   wpend_reg;
    logic [1:0]             in_kind_reg;
    logic [BYTE_W-1:0]      in_mosi_reg;
    logic                   in_keep_reg;
    logic [LOAD_ADDR_W-1:0] in_load_reg;
    action_t                act_reg;
    logic [ADDR_BITS-1:0]   op_addr_reg;
    logic [ADDR_BITS-1:0]   mask_reg;
    logic [ADDR_BITS-1:0]   cnt_reg;
    logic [BYTE_W-1:0]      res_miso_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TUSER_W-1:0]   m_tuser_reg;

    // Decode results.
    logic [BYTE_W-1:0]      dec_cmd;
    logic [POS_W-1:0]       dec_pos;
    logic [ADDR_BITS-1:0]   dec_addr;
    logic                   dec_latch;
    logic                   dec_sleep;
    logic                   dec_spend;
    logic                   dec_wpend;
    logic [BYTE_W-1:0]      dec_miso;
    action_t                dec_act;
    logic [ADDR_BITS-1:0]   dec_op_addr;

    // RAM port.
    logic                   ram_en;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_addr;
    logic [BYTE_W-1:0]      ram_wdata;
    logic [BYTE_W-1:0]      ram_rdata;

    logic                   erase_last;
    logic                   out_free;

    // A write or erase is refused without the latch or inside the protected sector.
    function automatic logic wr_rejected(input logic [ADDR_BITS-1:0] a,
                                         input logic latch, input logic prot);
        return !latch || (prot && ((a >> SECTOR_BITS) == '0));
    endfunction

    assign erase_last = ((cnt_reg & mask_reg) == mask_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    // Command decode of the held beat against the current engine state.
    always_comb
    begin
        logic [BYTE_W-1:0]    cmd_eff;
        logic [ADDR_BITS-1:0] shifted;
        logic                 do_release;

        dec_cmd     = cmd_reg;
        dec_pos     = pos_reg;
        dec_addr    = addr_reg;
        dec_latch   = latch_reg;
        dec_sleep   = sleep_reg;
        dec_spend   = spend_reg;
        dec_wpend   = wpend_reg;
        dec_miso    = '0;
        dec_act     = ACT_NONE;
        dec_op_addr = addr_reg;
        do_release  = 1'b0;
        cmd_eff     = (pos_reg == '0) ? in_mosi_reg : cmd_reg;
        shifted     = {addr_reg[ADDR_BITS-9:0], in_mosi_reg};

        case (in_kind_reg)
            KIND_XCHG:
            begin
                dec_cmd  = cmd_eff;
                dec_miso = (pos_reg == '0) ? '0 : in_mosi_reg;
                if (!sleep_reg || cmd_eff == CMD_RDP)
                begin
                    case (cmd_eff)
                        CMD_WREN:
                        begin
                            if (pos_reg == '0)
                            begin
                                dec_latch = 1'b1;
                            end
                        end
                        CMD_WRDI:
                        begin
                            if (pos_reg == '0)
                            begin
                                dec_latch = 1'b0;
                            end
                        end
                        CMD_RDID:
                        begin
                            case (pos_reg)
                                3'd1:    dec_miso = ID_MAKER;
                                3'd2:    dec_miso = ID_TYPE;
                                3'd3:    dec_miso = ID_SIZE;
                                default: dec_miso = dec_miso;
                            endcase
                        end
                        CMD_RDSR:
                        begin
                            dec_miso = '0;
                        end
                        CMD_READ, CMD_FAST, CMD_PW, CMD_PP, CMD_PE, CMD_SE:
                        begin
                            if (pos_reg == '0)
                            begin
                                dec_addr = '0;
                            end
                            else if (pos_reg <= 3'd3)
                            begin
                                dec_addr = shifted;
                                if (pos_reg == 3'd3 && cmd_eff inside {CMD_PE, CMD_SE})
                                begin
                                    if (wr_rejected(shifted, latch_reg, protect_reg))
                                    begin
                                        dec_cmd  = CMD_NONE;
                                        dec_miso = '0;
                                    end
                                    else
                                    begin
                                        dec_act     = (cmd_eff == CMD_PE) ? ACT_ERASE_PAGE
                                                                          : ACT_ERASE_SECTOR;
                                        dec_op_addr = shifted;
                                    end
                                end
                            end
                            else if (cmd_eff == CMD_READ ||
                                     (cmd_eff == CMD_FAST && pos_reg >= POS_MAX))
                            begin
                                dec_act  = ACT_READ;
                                dec_addr = addr_reg + 1'b1;
                            end
                            else if (cmd_eff inside {CMD_PW, CMD_PP})
                            begin
                                if (pos_reg == 3'd4 &&
                                    wr_rejected(addr_reg, latch_reg, protect_reg))
                                begin
                                    dec_cmd  = CMD_NONE;
                                    dec_miso = '0;
                                end
                                else
                                begin
                                    if (cmd_eff == CMD_PP)
                                    begin
                                        dec_act = ACT_AND;
                                    end
                                    else if (pos_reg == 3'd4)
                                    begin
                                        dec_act = ACT_ERASE_WRITE;
                                    end
                                    else
                                    begin
                                        dec_act = ACT_WRITE;
                                    end
                                    dec_addr = {addr_reg[ADDR_BITS-1:PAGE_BITS],
                                                addr_reg[PAGE_BITS-1:0] + 1'b1};
                                end
                            end
                        end
                        CMD_DP:
                        begin
                            dec_spend = (pos_reg == '0);
                        end
                        CMD_RDP:
                        begin
                            dec_wpend = (pos_reg == '0);
                        end
                        default:
                        begin
                            dec_miso = '0;
                        end
                    endcase

                    if (in_keep_reg)
                    begin
                        if (pos_reg < POS_MAX)
                        begin
                            dec_pos = pos_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        do_release = 1'b1;
                    end
                end
            end
            KIND_RELEASE:
            begin
                do_release = 1'b1;
            end
            KIND_LOAD:
            begin
                dec_act     = ACT_LOAD;
                dec_op_addr = ADDR_BITS'(in_load_reg);
            end
            default:
            begin
                dec_act = ACT_NONE;
            end
        endcase

        // Chip-select release: settle power-down and end any write command.
        if (do_release)
        begin
            dec_pos = '0;
            if (dec_spend)
            begin
                dec_sleep = 1'b1;
            end
            if (dec_wpend)
            begin
                dec_sleep = 1'b0;
            end
            dec_spend = 1'b0;
            dec_wpend = 1'b0;
            if (dec_cmd inside {CMD_PW, CMD_PP, CMD_PE, CMD_SE})
            begin
                dec_latch = 1'b0;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (dec_act)
                    ACT_READ, ACT_AND:
                        state_next = ST_READ;
                    ACT_ERASE_PAGE, ACT_ERASE_SECTOR, ACT_ERASE_WRITE:
                        state_next = ST_ERASE;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_ERASE:
            begin
                if (erase_last)
                begin
                    state_next = (act_reg == ACT_ERASE_WRITE) ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller: handshake and RAM port.
    always_comb
    begin
        s_tready  = 1'b0;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = op_addr_reg;
        ram_wdata = in_mosi_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_DECODE:
            begin
                ram_addr = dec_op_addr;
                ram_en   = dec_act inside {ACT_LOAD, ACT_WRITE, ACT_READ, ACT_AND};
                ram_we   = dec_act inside {ACT_LOAD, ACT_WRITE};
            end
            ST_READ:
            begin
                ram_en    = (act_reg == ACT_AND);
                ram_we    = (act_reg == ACT_AND);
                ram_wdata = ram_rdata & in_mosi_reg;
            end
            ST_ERASE:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = (op_addr_reg & ~mask_reg) | (cnt_reg & mask_reg);
                ram_wdata = BYTE_ERASED;
            end
            ST_WRITE:
            begin
                ram_en = 1'b1;
                ram_we = 1'b1;
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    // Controller state, engine state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            protect_reg <= 1'b1;
            cmd_reg     <= CMD_NONE;
            pos_reg     <= '0;
            addr_reg    <= '0;
            latch_reg   <= 1'b0;
            sleep_reg   <= 1'b0;
            spend_reg   <= 1'b0;
            wpend_reg   <= 1'b0;
            act_reg     <= ACT_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                protect_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DECODE)
            begin
                cmd_reg   <= dec_cmd;
                pos_reg   <= dec_pos;
                addr_reg  <= dec_addr;
                latch_reg <= dec_latch;
                sleep_reg <= dec_sleep;
                spend_reg <= dec_spend;
                wpend_reg <= dec_wpend;
                act_reg   <= dec_act;
            end
        end
    end

    // Held beat, operation address, erase walk and result byte.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser[1:0];
            in_keep_reg <= s_tuser[2];
            in_mosi_reg <= s_tdata[BYTE_W-1:0];
            in_load_reg <= s_tdata[BYTE_W +: LOAD_ADDR_W];
        end
        if (state_reg == ST_DECODE)
        begin
            op_addr_reg  <= dec_op_addr;
            res_miso_reg <= dec_miso;
            mask_reg     <= (dec_act == ACT_ERASE_SECTOR) ? SEC_MASK : PAGE_MASK;
            cnt_reg      <= '0;
        end
        if (state_reg == ST_ERASE)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == ST_READ && act_reg == ACT_READ)
        begin
            res_miso_reg <= ram_rdata;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            m_tdata_reg <= res_miso_reg;
            m_tuser_reg <= {sleep_reg, latch_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Byte store.
    sfce_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (1 << ADDR_BITS)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

`ifndef ASSERT_OFF
    // An accepted beat is decoded in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_DECODE)
        else $error("accepted beat not decoded");

    // The store is never written while the engine waits for a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !(ram_en && ram_we))
        else $error("store written while idle");

    // The byte position never passes its saturation value.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("byte position out of range");

    // Only one power-down transition can be pending in a selection.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(spend_reg && wpend_reg))
        else $error("sleep and wake both pending");

    // The erase walk stays inside the block being erased.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ERASE |-> (cnt_reg & ~mask_reg) == '0)
        else $error("erase walk left its block");
`endif

endmodule

/* src/sfce_ram.sv */
// Generic single-port synchronous RAM with a registered read port.
// No dependencies; used by the command engine for the flash byte store.
module sfce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: write, or read with the data registered in rdata.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
